>>> src/rrrl_pkg.sv
`default_nettype none

package rrrl_pkg;

    // Request kinds carried in the slave-side tuser
    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_NEXT   = 2'd2;
    localparam logic [1:0] REQ_SET    = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_PRESENT   = 2'd2;
    localparam logic [1:0] ST_NO_NEXT   = 2'd3;

    // Field widths of the stream payloads
    localparam int ID_W     = 4;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int IN_W     = 8;
    localparam int OUT_W    = 24;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SUCC,
        S_WALK,
        S_TAIL,
        S_NEXT,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

>>> src/round_robin_ready_list_top.sv
`default_nettype none

// Channel   | Dir | Signals                        | Contents
// s_axis    | in  | tvalid, tready, tdata, tuser   | request: proc_id, req_type
// m_axis    | out | tvalid, tready, tdata          | result: status, ids, count, flags
//
// One request at a time. Set current, duplicate add, rejected requests and add to an
// empty list go straight from decode to the result; add to a non-empty list walks the
// chain from head to tail, remove walks it to find the predecessor unless the entry is
// the head, and next reads the current entry's link. The link table has one registered
// read port, and each step of the chain walk costs one read of it.
// rst_n clears the sequencer, head, current, count and the per-entry listed bits;
// the link table itself needs no clearing. A stalled result sits in the output
// register while the next request is already taken.

module round_robin_ready_list_top
    import rrrl_pkg::*;
#(
    parameter int MAX_IDS = 16
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [IN_W-1:0]      s_axis_tdata,  // [3:0] proc_id, [7:4] zero
    input  wire logic [REQ_W-1:0]     s_axis_tuser,  // [1:0] req_type
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [OUT_W-1:0]          m_axis_tdata   // [1:0] status, [5:2] next_id,
                                                     // [9:6] current_id, [10] current_valid,
                                                     // [15:11] active_count,
                                                     // [16] list_empty, [23:17] zero
);

    localparam int IW = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
    localparam int LW = $clog2(MAX_IDS + 1);
    localparam int CW = $clog2(MAX_IDS + 1);
    localparam logic [LW-1:0] LINK_END = LW'(MAX_IDS);

    // Registers
    state_t                 state_reg, state_next;
    logic [REQ_W-1:0]       req_reg, req_next;
    logic [ID_W-1:0]        id_reg, id_next;
    logic [LW-1:0]          head_reg, head_next;
    logic [ID_W-1:0]        cur_reg, cur_next;
    logic                   cur_valid_reg, cur_valid_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [MAX_IDS-1:0]     listed_reg, listed_next;
    logic [IW-1:0]          k_reg, k_next;
    logic [LW-1:0]          target_reg, target_next;
    logic [LW-1:0]          wval_reg, wval_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [ID_W-1:0]        nxt_reg, nxt_next;
    logic                   m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]       m_data_reg, m_data_next;

    // Link table
    logic [LW-1:0]          link_mem [MAX_IDS];
    logic [LW-1:0]          rdata_reg;
    logic                   mem_we;
    logic [IW-1:0]          mem_waddr;
    logic [LW-1:0]          mem_wdata;
    logic [IW-1:0]          mem_raddr;

    // Shared decode
    logic [IW-1:0]          id_idx;
    logic [IW-1:0]          cur_idx;
    logic                   id_ok;
    logic                   id_listed;
    logic                   head_empty;
    logic                   next_ok;
    logic                   walk_hit;
    logic                   out_free;

    assign id_idx     = IW'(id_reg);
    assign cur_idx    = IW'(cur_reg);
    assign id_ok      = (32'(id_reg) < 32'(MAX_IDS));
    assign id_listed  = id_ok && listed_reg[id_idx];
    assign head_empty = (head_reg == LINK_END);
    assign next_ok    = !head_empty && cur_valid_reg && (32'(cur_reg) < 32'(MAX_IDS))
                        && listed_reg[cur_idx];
    assign walk_hit   = (rdata_reg == target_reg);
    assign out_free   = !m_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_DONE;
                if (id_ok)
                begin
                    case (req_reg)
                        REQ_ADD:    if (!id_listed && !head_empty) state_next = S_WALK;
                        REQ_REMOVE: if (id_listed) state_next = S_SUCC;
                        REQ_NEXT:   if (next_ok) state_next = S_NEXT;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_SUCC:
            begin
                state_next = (head_reg == LW'(id_reg)) ? S_DONE : S_WALK;
            end
            S_WALK:
            begin
                if (walk_hit)
                    state_next = (req_reg == REQ_ADD) ? S_TAIL : S_DONE;
            end
            S_TAIL:   state_next = S_DONE;
            S_NEXT:   state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Datapath, table access and result register
    always_comb
    begin
        req_next       = req_reg;
        id_next        = id_reg;
        head_next      = head_reg;
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        count_next     = count_reg;
        listed_next    = listed_reg;
        k_next         = k_reg;
        target_next    = target_reg;
        wval_next      = wval_reg;
        status_next    = status_reg;
        nxt_next       = nxt_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        m_data_next    = m_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = k_reg;
        mem_wdata      = wval_reg;
        mem_raddr      = k_reg;

        case (state_reg)
            S_IDLE:
            begin
                // Capture the request on transfer
                if (s_axis_tvalid)
                begin
                    req_next = s_axis_tuser;
                    id_next  = s_axis_tdata[ID_W-1:0];
                end
            end
            S_DECIDE:
            begin
                status_next = ST_OK;
                nxt_next    = '0;
                if (!id_ok)
                    status_next = ST_NOT_FOUND;
                else
                begin
                    case (req_reg)
                        REQ_ADD:
                        begin
                            if (id_listed)
                                status_next = ST_PRESENT;
                            else if (head_empty)
                            begin
                                // First entry becomes head and current
                                mem_we              = 1'b1;
                                mem_waddr           = id_idx;
                                mem_wdata           = LINK_END;
                                head_next           = LW'(id_reg);
                                cur_next            = id_reg;
                                cur_valid_next      = 1'b1;
                                listed_next[id_idx] = 1'b1;
                                count_next          = count_reg + 1'b1;
                            end
                            else
                            begin
                                // Walk from head to the tail
                                mem_raddr   = IW'(head_reg);
                                k_next      = IW'(head_reg);
                                target_next = LINK_END;
                                wval_next   = LW'(id_reg);
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (!id_listed)
                                status_next = ST_NOT_FOUND;
                            else
                                mem_raddr = id_idx;
                        end
                        REQ_NEXT:
                        begin
                            if (!next_ok)
                                status_next = ST_NO_NEXT;
                            else
                                mem_raddr = cur_idx;
                        end
                        default:
                        begin
                            cur_next       = id_reg;
                            cur_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_SUCC:
            begin
                // Unlink at head directly, else search for the predecessor
                if (head_reg == LW'(id_reg))
                begin
                    head_next           = rdata_reg;
                    listed_next[id_idx] = 1'b0;
                    count_next          = count_reg - 1'b1;
                end
                else
                begin
                    mem_raddr   = IW'(head_reg);
                    k_next      = IW'(head_reg);
                    target_next = LW'(id_reg);
                    wval_next   = rdata_reg;
                end
            end
            S_WALK:
            begin
                if (walk_hit)
                begin
                    // Relink the entry found
                    mem_we    = 1'b1;
                    mem_waddr = k_reg;
                    mem_wdata = wval_reg;
                    if (req_reg == REQ_REMOVE)
                    begin
                        listed_next[id_idx] = 1'b0;
                        count_next          = count_reg - 1'b1;
                    end
                end
                else
                begin
                    // Advance along the chain
                    k_next    = IW'(rdata_reg);
                    mem_raddr = IW'(rdata_reg);
                end
            end
            S_TAIL:
            begin
                mem_we              = 1'b1;
                mem_waddr           = id_idx;
                mem_wdata           = LINK_END;
                listed_next[id_idx] = 1'b1;
                count_next          = count_reg + 1'b1;
            end
            S_NEXT:
            begin
                nxt_next = (rdata_reg == LINK_END) ? ID_W'(head_reg) : ID_W'(rdata_reg);
            end
            S_DONE:
            begin
                // Load the result once the output register is free
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {7'd0,
                                    head_empty,
                                    COUNT_W'(count_reg),
                                    cur_valid_reg,
                                    cur_valid_reg ? cur_reg : {ID_W{1'b0}},
                                    nxt_reg,
                                    status_reg};
                end
            end
            default:
            begin
                status_next = status_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= LINK_END;
            cur_reg       <= '0;
            cur_valid_reg <= 1'b0;
            count_reg     <= '0;
            listed_reg    <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            cur_reg       <= cur_next;
            cur_valid_reg <= cur_valid_next;
            count_reg     <= count_next;
            listed_reg    <= listed_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        id_reg     <= id_next;
        k_reg      <= k_next;
        target_reg <= target_next;
        wval_reg   <= wval_next;
        status_reg <= status_next;
        nxt_reg    <= nxt_next;
        m_data_reg <= m_data_next;
    end

    // Link table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            link_mem[mem_waddr] <= mem_wdata;
        rdata_reg <= link_mem[mem_raddr];
    end

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(MAX_IDS))
        else $error("active count above table depth");

    a_count_listed: assert property (@(posedge clk) disable iff (!rst_n)
        32'($countones(listed_reg)) == 32'(count_reg))
        else $error("listed bits disagree with active count");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        head_empty == (count_reg == '0))
        else $error("head pointer disagrees with active count");

    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_DONE) |-> !mem_we)
        else $error("link table written outside a request");

    a_transfer_decide: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == S_DECIDE))
        else $error("request transfer did not start decoding");

endmodule

`default_nettype wire
